@@ rtl/bse_pkg.sv @@
package bse_pkg;

  // Store geometry
  localparam int STORE_BYTES = 128;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BIT_IDX_W   = 10;
  localparam int CNT_W       = 11;
  localparam int VB_W        = 8;
  localparam int CMD_W       = 4;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SET      = 4'd0,
    CMD_CLEAR    = 4'd1,
    CMD_TEST     = 4'd2,
    CMD_AND      = 4'd3,
    CMD_OR       = 4'd4,
    CMD_XOR      = 4'd5,
    CMD_ANDN     = 4'd6,
    CMD_ORN      = 4'd7,
    CMD_WRITE    = 4'd8,
    CMD_INVERT   = 4'd9,
    CMD_FILL     = 4'd10,
    CMD_POPCOUNT = 4'd11,
    CMD_RANK     = 4'd12,
    CMD_LIST     = 4'd13
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST,
    ST_WALK,
    ST_WDONE
  } state_t;

  // Access request towards the bitmap store
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

  // Set bits in a nibble
  localparam logic [2:0] ONES_NIB [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  function automatic logic [3:0] ones8(input logic [7:0] b);
    return {1'b0, ONES_NIB[b[3:0]]} + {1'b0, ONES_NIB[b[7:4]]};
  endfunction

endpackage

@@ rtl/bse_store.sv @@
module bse_store (
  input  logic             clk,
  input  logic             rst_n,
  input  bse_pkg::mem_req_t req,
  output logic [7:0]       rd_data
);
  import bse_pkg::*;

  logic [7:0]             mem_r [STORE_BYTES];
  logic [STORE_BYTES-1:0] vld_r;
  logic [7:0]             rd_data_r;
  logic                   rd_vld_r;

  // Bitmap bytes, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  // Written flags: a byte never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : 8'd0;

endmodule

@@ rtl/bitset_store_engine_unit.sv @@
// Channel | Ports                                                  | Handshake
// input   | in_cmd, in_bit_pos, in_byte_addr, in_operand_byte      | in_valid / in_stall
// result  | out_byte_value .. out_status (seven fields)            | out_valid / out_stall
// config  | cfg_vector_bytes                                       | cfg_valid / cfg_ready
//
// Bit and byte commands read at accept, then modify and write back (test only reads); unused
// codes read and give a bare last result. List gives one result per set bit of the byte, or
// one bare result for an empty byte. Invert, fill and popcount walk the n bytes in use, and
// rank walks bytes 0 to bit_pos/8, one byte per cycle.
// Reset clears per-byte written flags at once, so the store reads as zero straight away.
// A full, stalled output register holds the sequencer in its emitting state.
module bitset_store_engine_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bse_pkg::CMD_W-1:0]      in_cmd,
  input  logic [bse_pkg::BIT_IDX_W-1:0]  in_bit_pos,
  input  logic [bse_pkg::ADDR_W-1:0]     in_byte_addr,
  input  logic [7:0]                     in_operand_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte_value,
  output logic                           out_bit_value,
  output logic [bse_pkg::CNT_W-1:0]      out_count,
  output logic [bse_pkg::BIT_IDX_W-1:0]  out_index_out,
  output logic                           out_found,
  output logic                           out_last,
  output logic                           out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bse_pkg::VB_W-1:0]       cfg_vector_bytes
);
  import bse_pkg::*;

  state_t                 state_r, state_nxt;
  logic [VB_W-1:0]        vbytes_r;
  logic [CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [BIT_IDX_W-1:0]   bi_r, bi_nxt;
  logic [ADDR_W-1:0]      ba_r, ba_nxt;
  logic [7:0]             op_r, op_nxt;
  logic [ADDR_W-1:0]      ptr_r, ptr_nxt;
  logic                   issue_done_r, issue_done_nxt;
  logic                   pvld_r, pvld_nxt;
  logic [ADDR_W-1:0]      paddr_r, paddr_nxt;
  logic [CNT_W-1:0]       acc_r, acc_nxt;
  logic [7:0]             rbyte_r, rbyte_nxt;
  logic [7:0]             lst_r, lst_nxt;
  logic [7:0]             lbyte_r, lbyte_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             obyte_r, obyte_nxt;
  logic                   obit_r, obit_nxt;
  logic [CNT_W-1:0]       ocnt_r, ocnt_nxt;
  logic [BIT_IDX_W-1:0]   oidx_r, oidx_nxt;
  logic                   ofound_r, ofound_nxt;
  logic                   olast_r, olast_nxt;
  logic                   ostat_r, ostat_nxt;

  mem_req_t               req;
  logic [7:0]             rd_data;

  logic [VB_W-1:0]        used_n;
  logic [ADDR_W-1:0]      bbyte;
  logic [7:0]             mask;
  logic                   is_bit, is_byte, is_walk, oor, out_free;
  logic [ADDR_W-1:0]      walk_end;
  logic [2:0]             low_bit;
  logic [7:0]             rest;
  logic [7:0]             nb;

  // Load of the output register
  logic                   ld;
  logic [7:0]             f_byte;
  logic                   f_bit;
  logic [CNT_W-1:0]       f_cnt;
  logic [BIT_IDX_W-1:0]   f_idx;
  logic                   f_found;
  logic                   f_last;
  logic                   f_stat;

  bse_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  // Bytes in use, clamped to 1..STORE_BYTES
  always_comb begin
    if (vbytes_r == '0) begin
      used_n = VB_W'(1);
    end else if (vbytes_r > VB_W'(STORE_BYTES)) begin
      used_n = VB_W'(STORE_BYTES);
    end else begin
      used_n = vbytes_r;
    end
  end

  // Decode of the held request
  assign bbyte   = bi_r[BIT_IDX_W-1:3];
  assign mask    = 8'd1 << bi_r[2:0];
  assign is_bit  = (cmd_r == CMD_SET) || (cmd_r == CMD_CLEAR) || (cmd_r == CMD_TEST) ||
                   (cmd_r == CMD_RANK);
  assign is_byte = ((cmd_r >= CMD_AND) && (cmd_r <= CMD_WRITE)) || (cmd_r == CMD_LIST);
  assign is_walk = (cmd_r == CMD_INVERT) || (cmd_r == CMD_FILL) ||
                   (cmd_r == CMD_POPCOUNT) || (cmd_r == CMD_RANK);
  assign oor     = (is_bit  && ({1'b0, bbyte} >= used_n)) ||
                   (is_byte && ({1'b0, ba_r}  >= used_n));
  assign walk_end = (cmd_r == CMD_RANK) ? bbyte : ADDR_W'(used_n - VB_W'(1));
  assign out_free = !out_valid_r || !out_stall;

  // Lowest set bit of the remaining list byte
  always_comb begin
    low_bit = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (lst_r[i]) begin
        low_bit = 3'(i);
      end
    end
  end
  assign rest = lst_r & ~(8'd1 << low_bit);

  // Modified byte for bit and byte commands
  always_comb begin
    case (cmd_r)
      CMD_SET:   nb = rd_data | mask;
      CMD_CLEAR: nb = rd_data & ~mask;
      CMD_AND:   nb = rd_data & op_r;
      CMD_OR:    nb = rd_data | op_r;
      CMD_XOR:   nb = rd_data ^ op_r;
      CMD_ANDN:  nb = rd_data & ~op_r;
      CMD_ORN:   nb = rd_data | ~op_r;
      CMD_WRITE: nb = op_r;
      default:   nb = rd_data;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (is_walk && !oor) begin
          state_nxt = ST_WALK;
        end else if (out_free) begin
          if ((cmd_r == CMD_LIST) && !oor && (rd_data != 8'd0)) begin
            state_nxt = ST_LIST;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LIST: begin
        if (out_free && (rest == 8'd0)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (issue_done_r && !pvld_r) begin
          state_nxt = ST_WDONE;
        end
      end
      ST_WDONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, store requests and result loads
  always_comb begin
    cmd_nxt        = cmd_r;
    bi_nxt         = bi_r;
    ba_nxt         = ba_r;
    op_nxt         = op_r;
    ptr_nxt        = ptr_r;
    issue_done_nxt = issue_done_r;
    pvld_nxt       = pvld_r;
    paddr_nxt      = paddr_r;
    acc_nxt        = acc_r;
    rbyte_nxt      = rbyte_r;
    lst_nxt        = lst_r;
    lbyte_nxt      = lbyte_r;
    req            = '0;
    ld             = 1'b0;
    f_byte         = 8'd0;
    f_bit          = 1'b0;
    f_cnt          = '0;
    f_idx          = '0;
    f_found        = 1'b0;
    f_last         = 1'b1;
    f_stat         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_cmd;
          bi_nxt         = in_bit_pos;
          ba_nxt         = in_byte_addr;
          op_nxt         = in_operand_byte;
          ptr_nxt        = '0;
          issue_done_nxt = 1'b0;
          pvld_nxt       = 1'b0;
          acc_nxt        = '0;
          req.rd_en      = 1'b1;
          if ((in_cmd <= CMD_TEST) || (in_cmd == CMD_RANK)) begin
            req.rd_addr = in_bit_pos[BIT_IDX_W-1:3];
          end else begin
            req.rd_addr = in_byte_addr;
          end
        end
      end
      ST_EXEC: begin
        if (!(is_walk && !oor) && out_free) begin
          ld = 1'b1;
          if (oor) begin
            f_stat = 1'b1;
          end else if (cmd_r == CMD_LIST) begin
            lst_nxt   = rd_data;
            lbyte_nxt = rd_data;
            // a non-empty byte is listed from the list state
            ld        = (rd_data == 8'd0);
          end else if (is_bit || is_byte) begin
            f_byte      = nb;
            f_bit       = (cmd_r == CMD_TEST) && ((nb & mask) != 8'd0);
            req.wr_en   = (cmd_r != CMD_TEST);
            req.wr_addr = is_bit ? bbyte : ba_r;
            req.wr_data = nb;
          end
        end
      end
      ST_LIST: begin
        if (out_free) begin
          ld      = 1'b1;
          f_byte  = lbyte_r;
          f_idx   = {ba_r, low_bit};
          f_found = 1'b1;
          f_last  = (rest == 8'd0);
          lst_nxt = rest;
        end
      end
      ST_WALK: begin
        // issue side: one byte a cycle
        pvld_nxt = 1'b0;
        if (!issue_done_r) begin
          if (cmd_r == CMD_FILL) begin
            req.wr_en   = 1'b1;
            req.wr_addr = ptr_r;
            req.wr_data = op_r;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = ptr_r;
            pvld_nxt    = 1'b1;
            paddr_nxt   = ptr_r;
          end
          if (ptr_r == walk_end) begin
            issue_done_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r + ADDR_W'(1);
          end
        end
        // process side: data read in the previous cycle
        if (pvld_r) begin
          case (cmd_r)
            CMD_INVERT: begin
              req.wr_en   = 1'b1;
              req.wr_addr = paddr_r;
              req.wr_data = ~rd_data;
            end
            CMD_POPCOUNT: begin
              acc_nxt = acc_r + CNT_W'(ones8(rd_data));
            end
            CMD_RANK: begin
              if (paddr_r < bbyte) begin
                acc_nxt = acc_r + CNT_W'(ones8(rd_data));
              end else begin
                acc_nxt   = acc_r + CNT_W'(ones8(rd_data & (mask - 8'd1)));
                rbyte_nxt = rd_data;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WDONE: begin
        if (out_free) begin
          ld = 1'b1;
          if (cmd_r == CMD_RANK) begin
            f_byte = rbyte_r;
            f_cnt  = acc_r;
          end else if (cmd_r == CMD_POPCOUNT) begin
            f_cnt = acc_r;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    obyte_nxt     = obyte_r;
    obit_nxt      = obit_r;
    ocnt_nxt      = ocnt_r;
    oidx_nxt      = oidx_r;
    ofound_nxt    = ofound_r;
    olast_nxt     = olast_r;
    ostat_nxt     = ostat_r;
    if (ld) begin
      out_valid_nxt = 1'b1;
      obyte_nxt     = f_byte;
      obit_nxt      = f_bit;
      ocnt_nxt      = f_cnt;
      oidx_nxt      = f_idx;
      ofound_nxt    = f_found;
      olast_nxt     = f_last;
      ostat_nxt     = f_stat;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      vbytes_r     <= VB_W'(STORE_BYTES);
      issue_done_r <= 1'b0;
      pvld_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      issue_done_r <= issue_done_nxt;
      pvld_r       <= pvld_nxt;
      if (cfg_valid && cfg_ready) begin
        vbytes_r <= cfg_vector_bytes;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    bi_r     <= bi_nxt;
    ba_r     <= ba_nxt;
    op_r     <= op_nxt;
    ptr_r    <= ptr_nxt;
    paddr_r  <= paddr_nxt;
    acc_r    <= acc_nxt;
    rbyte_r  <= rbyte_nxt;
    lst_r    <= lst_nxt;
    lbyte_r  <= lbyte_nxt;
    obyte_r  <= obyte_nxt;
    obit_r   <= obit_nxt;
    ocnt_r   <= ocnt_nxt;
    oidx_r   <= oidx_nxt;
    ofound_r <= ofound_nxt;
    olast_r  <= olast_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign cfg_ready      = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_byte_value = obyte_r;
  assign out_bit_value  = obit_r;
  assign out_count      = ocnt_r;
  assign out_index_out  = oidx_r;
  assign out_found      = ofound_r;
  assign out_last       = olast_r;
  assign out_status     = ostat_r;

endmodule

@@ rtl/bse_checker.sv @@
module bse_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [7:0]                     out_byte_value,
  input logic                           out_bit_value,
  input logic [bse_pkg::CNT_W-1:0]      out_count,
  input logic [bse_pkg::BIT_IDX_W-1:0]  out_index_out,
  input logic                           out_found,
  input logic                           out_last,
  input logic                           out_status
);
  import bse_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_value) &&
      $stable(out_count) && $stable(out_index_out) && $stable(out_last))
    else $error("stalled result changed");

  // Out-of-range requests give a bare final status result
  a_oor_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && !out_found && (out_byte_value == 8'd0) &&
      (out_count == '0) && !out_bit_value)
    else $error("out-of-range result carries data");

  // No listed bit means no index
  a_idx_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_index_out == '0))
    else $error("index without found");

  // A listed bit lies in the reported byte
  a_found_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_byte_value[out_index_out[2:0]])
    else $error("listed bit not set in byte");

endmodule

bind bitset_store_engine_unit bse_checker u_bse_checker (.*);

@@ tb/bitset_store_engine_unit_tb.sv @@
`timescale 1ns / 100ps

module bitset_store_engine_unit_tb;
  import bse_pkg::*;

  // Codes outside the command set: the block must answer with a bare last
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 4'd14;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 4'd15;
  localparam logic [CMD_W-1:0] COMBINE_OPS [6] = '{
    CMD_AND, CMD_OR, CMD_XOR, CMD_ANDN, CMD_ORN, CMD_WRITE
  };
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [BIT_IDX_W-1:0] bit_pos;
    logic [ADDR_W-1:0]    byte_addr;
    logic [7:0]           operand;
  } bitset_req_t;

  typedef struct packed {
    logic [7:0]           byte_value;
    logic                 bit_value;
    logic [CNT_W-1:0]     count;
    logic [BIT_IDX_W-1:0] index_out;
    logic                 found;
    logic                 last;
    logic                 status;
  } bitset_reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd = '0;
  logic [BIT_IDX_W-1:0] in_bit_pos = '0;
  logic [ADDR_W-1:0]    in_byte_addr = '0;
  logic [7:0]           in_operand_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte_value;
  logic                 out_bit_value;
  logic [CNT_W-1:0]     out_count;
  logic [BIT_IDX_W-1:0] out_index_out;
  logic                 out_found;
  logic                 out_last;
  logic                 out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [VB_W-1:0]      cfg_vector_bytes = '0;

  // Shadow copy of the bitmap and the size register
  logic [7:0]    shadow_bitmap [STORE_BYTES];
  logic [VB_W-1:0] shadow_vbytes = 8'd128;
  bitset_reply_t awaited_replies [$];

  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  bitset_store_engine_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_bit_pos       (in_bit_pos),
    .in_byte_addr     (in_byte_addr),
    .in_operand_byte  (in_operand_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_value   (out_byte_value),
    .out_bit_value    (out_bit_value),
    .out_count        (out_count),
    .out_index_out    (out_index_out),
    .out_found        (out_found),
    .out_last         (out_last),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_vector_bytes (cfg_vector_bytes)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[bitset_store_engine_unit] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: free-running, random, or a fixed 2-in-5 pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(40, 250);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 40);
      default: out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  task automatic note_failure(input string msg);
    $display("%0t ns: %s", $time, msg);
    failures++;
  endtask

  function automatic int unsigned used_bytes();
    if (shadow_vbytes == 0) return 1;
    if (shadow_vbytes > STORE_BYTES) return STORE_BYTES;
    return shadow_vbytes;
  endfunction

  function automatic int unsigned ones_in_byte(input logic [7:0] b);
    int unsigned c;
    c = 0;
    for (int i = 0; i < 8; i++) c += b[i];
    return c;
  endfunction

  // Apply one request to the shadow bitmap and queue the replies it should give
  function automatic void execute_bitset_cmd(input bitset_req_t r);
    int unsigned   n;
    int unsigned   cnt;
    int unsigned   bbyte;
    logic [7:0]    mask;
    logic [7:0]    b;
    bitset_reply_t rep;
    n = used_bytes();
    bbyte = r.bit_pos[BIT_IDX_W-1:3];
    mask = 8'd1 << r.bit_pos[2:0];
    rep = '0;
    rep.last = 1'b1;
    case (r.cmd)
      CMD_SET, CMD_CLEAR, CMD_TEST, CMD_RANK: begin
        if (bbyte >= n) begin
          rep.status = 1'b1;
        end else begin
          if (r.cmd == CMD_SET) shadow_bitmap[bbyte] |= mask;
          if (r.cmd == CMD_CLEAR) shadow_bitmap[bbyte] &= ~mask;
          b = shadow_bitmap[bbyte];
          rep.byte_value = b;
          if (r.cmd == CMD_TEST) rep.bit_value = |(b & mask);
          if (r.cmd == CMD_RANK) begin
            cnt = ones_in_byte(b & (mask - 8'd1));
            for (int i = 0; i < bbyte; i++) cnt += ones_in_byte(shadow_bitmap[i]);
            rep.count = CNT_W'(cnt);
          end
        end
        awaited_replies.push_back(rep);
      end
      CMD_AND, CMD_OR, CMD_XOR, CMD_ANDN, CMD_ORN, CMD_WRITE, CMD_LIST: begin
        if (r.byte_addr >= n) begin
          rep.status = 1'b1;
          awaited_replies.push_back(rep);
        end else begin
          b = shadow_bitmap[r.byte_addr];
          case (r.cmd)
            CMD_AND:   b = b & r.operand;
            CMD_OR:    b = b | r.operand;
            CMD_XOR:   b = b ^ r.operand;
            CMD_ANDN:  b = b & ~r.operand;
            CMD_ORN:   b = b | ~r.operand;
            CMD_WRITE: b = r.operand;
            default: ;
          endcase
          shadow_bitmap[r.byte_addr] = b;
          if (r.cmd != CMD_LIST || b == 8'd0) begin
            rep.byte_value = b;
            awaited_replies.push_back(rep);
          end else begin
            // one reply per set bit, lowest first; last on the highest one
            for (int i = 0; i < 8; i++) begin
              if (b[i]) begin
                rep.byte_value = b;
                rep.index_out = {r.byte_addr, i[2:0]};
                rep.found = 1'b1;
                rep.last = ((b >> i >> 1) == 8'd0);
                awaited_replies.push_back(rep);
              end
            end
          end
        end
      end
      CMD_INVERT, CMD_FILL, CMD_POPCOUNT: begin
        cnt = 0;
        for (int i = 0; i < n; i++) begin
          if (r.cmd == CMD_INVERT) shadow_bitmap[i] = ~shadow_bitmap[i];
          else if (r.cmd == CMD_FILL) shadow_bitmap[i] = r.operand;
          else cnt += ones_in_byte(shadow_bitmap[i]);
        end
        if (r.cmd == CMD_POPCOUNT) rep.count = CNT_W'(cnt);
        awaited_replies.push_back(rep);
      end
      default: awaited_replies.push_back(rep);
    endcase
  endfunction

  // Offer one request; the sender often idles between bursts of random length
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BIT_IDX_W-1:0] bi,
                              input logic [ADDR_W-1:0] ba, input logic [7:0] op);
    int unsigned gap;
    bitset_req_t r;
    r = '{cmd: cmd, bit_pos: bi, byte_addr: ba, operand: op};
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_bit_pos      <= bi;
    in_byte_addr    <= ba;
    in_operand_byte <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    execute_bitset_cmd(r);
  endtask

  task automatic wait_drained();
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_vector_size(input logic [VB_W-1:0] v);
    cfg_valid        <= 1'b1;
    cfg_vector_bytes <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid     <= 1'b0;
    shadow_vbytes = v;
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    bitset_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        note_failure("result arrived with none awaited");
      end else begin
        want = awaited_replies.pop_front();
        if (out_byte_value !== want.byte_value)
          note_failure($sformatf("byte_value got %0h want %0h", out_byte_value,
                                 want.byte_value));
        if (out_bit_value !== want.bit_value)
          note_failure($sformatf("bit_value got %0b want %0b", out_bit_value,
                                 want.bit_value));
        if (out_count !== want.count)
          note_failure($sformatf("count got %0d want %0d", out_count, want.count));
        if (out_index_out !== want.index_out)
          note_failure($sformatf("index_out got %0d want %0d", out_index_out,
                                 want.index_out));
        if (out_found !== want.found)
          note_failure($sformatf("found got %0b want %0b", out_found, want.found));
        if (out_last !== want.last)
          note_failure($sformatf("last got %0b want %0b", out_last, want.last));
        if (out_status !== want.status)
          note_failure($sformatf("status got %0b want %0b", out_status, want.status));
      end
    end
  end

  // Store straight out of reset: nothing set, listing gives an empty reply
  task automatic test_reset_contents();
    send_request(CMD_POPCOUNT, 10'd0, 7'd0, 8'd0);
    send_request(CMD_LIST, 10'd0, 7'd127, 8'd0);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Single-bit commands at both ends of the vector, plus the unused codes
  task automatic test_bit_commands();
    write_vector_size(8'd255);
    send_request(CMD_SET, 10'd0, 7'd0, 8'd0);
    send_request(CMD_SET, 10'd1023, 7'd0, 8'd0);
    send_request(CMD_TEST, 10'd1023, 7'd0, 8'd0);
    send_request(CMD_CLEAR, 10'd1023, 7'd0, 8'd0);
    send_request(CMD_RANK, 10'd1023, 7'd0, 8'd0);
    send_request(CMD_SPARE_A, 10'd1023, 7'd127, 8'd255);
    send_request(CMD_SPARE_B, 10'd0, 7'd0, 8'd0);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Every byte combine on the top byte, then a list of it (several bits set) and of byte 0
  task automatic test_byte_commands();
    send_request(CMD_WRITE, 10'd0, 7'd127, 8'hFF);
    send_request(CMD_AND, 10'd0, 7'd127, 8'h0F);
    send_request(CMD_OR, 10'd0, 7'd127, 8'hA0);
    send_request(CMD_XOR, 10'd0, 7'd127, 8'hFF);
    send_request(CMD_ANDN, 10'd0, 7'd127, 8'h0F);
    send_request(CMD_ORN, 10'd0, 7'd127, 8'hFE);
    send_request(CMD_LIST, 10'd0, 7'd127, 8'd0);
    send_request(CMD_LIST, 10'd0, 7'd0, 8'd0);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Whole-vector walks over the full store, then a rank that walks the first bytes
  task automatic test_vector_commands();
    write_vector_size(8'd128);
    send_request(CMD_FILL, 10'd0, 7'd0, 8'hA5);
    send_request(CMD_POPCOUNT, 10'd0, 7'd0, 8'd0);
    send_request(CMD_INVERT, 10'd0, 7'd0, 8'd0);
    send_request(CMD_RANK, 10'd9, 7'd0, 8'd0);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // A size of zero acts as one byte: anything past byte 0 is refused
  task automatic test_out_of_range();
    write_vector_size(8'd0);
    send_request(CMD_SET, 10'd8, 7'd0, 8'd0);
    send_request(CMD_WRITE, 10'd0, 7'd1, 8'hFF);
    send_request(CMD_LIST, 10'd0, 7'd1, 8'd0);
    send_request(CMD_TEST, 10'd7, 7'd0, 8'd0);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Random mix at one vector size; indices mostly inside the vector
  task automatic test_random_mix(input logic [VB_W-1:0] size, input int unsigned items);
    int unsigned          n;
    int unsigned          pick;
    logic [CMD_W-1:0]     cmd;
    logic [BIT_IDX_W-1:0] bi;
    logic [ADDR_W-1:0]    ba;
    write_vector_size(size);
    n = used_bytes();
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      bi = ($urandom_range(0, 7) != 0) ? BIT_IDX_W'($urandom_range(0, n * 8 - 1))
                                       : BIT_IDX_W'($urandom_range(0, 1023));
      ba = ($urandom_range(0, 7) != 0) ? ADDR_W'($urandom_range(0, n - 1))
                                       : ADDR_W'($urandom_range(0, 127));
      if (pick < 12) cmd = CMD_SET;
      else if (pick < 20) cmd = CMD_CLEAR;
      else if (pick < 30) cmd = CMD_TEST;
      else if (pick < 50) cmd = COMBINE_OPS[$urandom_range(0, 5)];
      else if (pick < 62) cmd = CMD_RANK;
      else if (pick < 77) cmd = CMD_LIST;
      else if (pick < 81) cmd = CMD_INVERT;
      else if (pick < 85) cmd = CMD_FILL;
      else if (pick < 91) cmd = CMD_POPCOUNT;
      else if (pick < 93) cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      else cmd = CMD_SET;
      send_request(cmd, bi, ba, 8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) shadow_bitmap[i] = 8'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_contents();
    test_bit_commands();
    test_byte_commands();
    test_vector_commands();
    test_out_of_range();
    test_random_mix(8'd128, 70);
    test_random_mix(8'd1, 40);
    test_random_mix(8'd255, 60);
    test_random_mix(VB_W'($urandom_range(2, 127)), 70);
    test_random_mix(8'd0, 30);
    test_random_mix(VB_W'($urandom_range(1, 16)), 70);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_replies.size() != 0) note_failure("replies still awaited at end of run");
    if (failures == 0) begin
      $display("[bitset_store_engine_unit] OK");
    end else begin
      $display("[bitset_store_engine_unit] ERROR");
    end
    $finish;
  end

endmodule
